FILE: design/gspe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gspe_pkg
// shared constants for the grid shortest path engine
// ----------------------------------------------------------------------------
package gspe_pkg;

   localparam int unsigned COST_W = 13;

   localparam logic [COST_W-1:0] COST_WALL      = 13'd8191;
   localparam logic [COST_W-1:0] COST_AGENT     = 13'd8190;
   localparam logic [COST_W-1:0] COST_UNREACHED = 13'd8189;

   localparam logic [2:0] OP_CLEAR = 3'd0;
   localparam logic [2:0] OP_WALL  = 3'd1;
   localparam logic [2:0] OP_AGENT = 3'd2;
   localparam logic [2:0] OP_SRCH  = 3'd3;
   localparam logic [2:0] OP_QUERY = 3'd4;

   localparam logic CSR_ROWS = 1'b0;
   localparam logic CSR_COLS = 1'b1;

endpackage

FILE: design/grid_shortest_path_engine_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_shortest_path_engine_core
// unit cost four neighbor shortest path search over a grid held in one ram
// ----------------------------------------------------------------------------
// Each cell word in a single one-port ram holds {pred valid, pred row, pred col,
// visited, cost}. After reset a clearing pass writes all 2**(row bits + col bits)
// cells (4096 at the default size) before the first request is taken. A mark or
// query request reads its cell and then writes it or answers; an out-of-range or
// unknown request goes straight to the response, and a clear reads each cell in
// use and rewrites it unless it is a wall. A search writes the source, then for
// each extraction scans rows*cols cells through the ram port, marks the cell
// visited and does the four neighbor read-modify-writes; a last scan ends the
// search, followed when needed by a marking pass that rewrites each non-wall cell
// in use. One request is processed at a time; the response waits in an output
// register, so the next request can be accepted and processed and only stalls in
// its response state until the previous response has left.
module grid_shortest_path_engine_core #(
   parameter int unsigned MAX_ROWS = 64,
   parameter int unsigned MAX_COLS = 64
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_we,
   input  logic       csr_index,
   input  logic [6:0] csr_wdata,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [2:0] req_op,
   input  logic [5:0] req_row,
   input  logic [5:0] req_col,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [5:0] rsp_pred_row,
   output logic [5:0] rsp_pred_col,
   output logic       rsp_pred_valid
);
   import gspe_pkg::*;

   localparam int unsigned RW    = $clog2(MAX_ROWS);
   localparam int unsigned CW    = $clog2(MAX_COLS);
   localparam int unsigned DW    = RW + 1;
   localparam int unsigned CDW   = CW + 1;
   localparam int unsigned AW    = RW + CW;
   localparam int unsigned DEPTH = 1 << AW;
   localparam int unsigned WORDW = 1 + RW + CW + 1 + COST_W;

   typedef enum logic [11:0] {
      S_INIT  = 12'b000000000001,
      S_IDLE  = 12'b000000000010,
      S_CLRD  = 12'b000000000100,
      S_CLRW  = 12'b000000001000,
      S_RDW   = 12'b000000010000,
      S_MOD   = 12'b000000100000,
      S_SCAN  = 12'b000001000000,
      S_SCEND = 12'b000010000000,
      S_NBRD  = 12'b000100000000,
      S_NBWR  = 12'b001000000000,
      S_FLUSH = 12'b010000000000,
      S_RESP  = 12'b100000000000
   } state_type;

   typedef struct packed {
      logic          pv;
      logic [RW-1:0] pr;
      logic [CW-1:0] pc;
      logic          vis;
      logic [COST_W-1:0] cost;
   } cell_type;

   state_type state_ff, state_in;
   logic [DW-1:0]  rows_ff, cols_ff;
   logic [2:0]     op_ff, op_in;
   logic [RW-1:0]  tr_ff, tr_in, r_ff, r_in, br_ff, br_in;
   logic [CW-1:0]  tc_ff, tc_in, c_ff, c_in, bc_ff, bc_in;
   logic [COST_W-1:0] best_ff, best_in, bcost_ff, bcost_in;
   logic           found_ff, found_in, flush_ff, flush_in;
   logic [1:0]     nb_ff, nb_in;
   logic           rv_ff, rv_in;      // scan read in flight
   logic [RW-1:0]  sr_ff, sr_in;      // address of data arriving
   logic [CW-1:0]  sc_ff, sc_in;
   logic           sdone_ff, sdone_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [5:0]     rsp_r_ff, rsp_r_in, rsp_c_ff, rsp_c_in;
   logic           rsp_pv_ff, rsp_pv_in;
   logic [5:0]     out_r_ff, out_r_in, out_c_ff, out_c_in;
   logic           out_pv_ff, out_pv_in;
   logic [AW:0]    init_ff, init_in;

   logic           we;
   logic [AW-1:0]  addr;
   cell_type       wd, rd;
   logic [WORDW-1:0] rd_raw;

   gspe_ram #(.WIDTH(WORDW), .DEPTH(DEPTH)) u_ram (
      .clock(clock), .we(we), .addr(addr), .wdata(wd), .rdata(rd_raw)
   );
   assign rd = cell_type'(rd_raw);

   function automatic logic [DW-1:0] clamp_dim(input logic [6:0] v, input int unsigned mx);
      logic [DW-1:0] res;
      if (v == 7'd0) res = DW'(1);
      else if (32'(v) > mx) res = DW'(mx);
      else res = DW'(v);
      return res;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff <= clamp_dim(7'd64, MAX_ROWS);
         cols_ff <= clamp_dim(7'd64, MAX_COLS);
      end else if (csr_we) begin
         if (csr_index == CSR_ROWS) rows_ff <= clamp_dim(csr_wdata, MAX_ROWS);
         else rows_ff <= rows_ff;
         if (csr_index == CSR_COLS) cols_ff <= clamp_dim(csr_wdata, MAX_COLS);
      end
   end

   // neighbor of the extracted cell, clamped at the edges in use
   logic [RW-1:0] nr;
   logic [CW-1:0] nc;
   logic [COST_W-1:0] newc;
   always_comb begin
      nr = br_ff;
      nc = bc_ff;
      case (nb_ff)
         2'd0: nr = (br_ff != '0) ? br_ff - RW'(1) : '0;
         2'd1: nr = ({1'b0, br_ff} + DW'(1) < rows_ff) ? br_ff + RW'(1) : RW'(rows_ff - DW'(1));
         2'd2: nc = (bc_ff != '0) ? bc_ff - CW'(1) : '0;
         default: nc = ({1'b0, bc_ff} + CDW'(1) < cols_ff) ? bc_ff + CW'(1)
                                                          : CW'(cols_ff - CDW'(1));
      endcase
      newc = bcost_ff + COST_W'(1);
   end

   logic       range_ok;
   logic [5:0] hr_ff, hr_in, hc_ff, hc_in;
   assign range_ok = (9'(hr_ff) < 9'(rows_ff)) && (9'(hc_ff) < 9'(cols_ff));

   logic last_r, last_c;
   assign last_c = ({1'b0, c_ff} + CDW'(1) == cols_ff);
   assign last_r = ({1'b0, r_ff} + DW'(1) == rows_ff);

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      op_in = op_ff; tr_in = tr_ff; tc_in = tc_ff; hr_in = hr_ff; hc_in = hc_ff;
      r_in = r_ff; c_in = c_ff; br_in = br_ff; bc_in = bc_ff;
      best_in = best_ff; bcost_in = bcost_ff; found_in = found_ff;
      flush_in = flush_ff; nb_in = nb_ff;
      rv_in = 1'b0; sr_in = sr_ff; sc_in = sc_ff; sdone_in = sdone_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_r_in = rsp_r_ff; rsp_c_in = rsp_c_ff; rsp_pv_in = rsp_pv_ff;
      out_r_in = out_r_ff; out_c_in = out_c_ff; out_pv_in = out_pv_ff;
      init_in = init_ff;
      we = 1'b0;
      addr = {r_ff, c_ff};
      wd = rd;
      unique case (state_ff)
         S_INIT: begin
            we = 1'b1;
            addr = init_ff[AW-1:0];
            wd = '{pv: 1'b0, pr: '0, pc: '0, vis: 1'b0, cost: COST_UNREACHED};
            init_in = init_ff + (AW+1)'(1);
            if (init_ff == (AW+1)'(DEPTH - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid && req_ready) begin
               op_in = req_op; hr_in = req_row; hc_in = req_col;
               tr_in = RW'(req_row); tc_in = CW'(req_col);
               r_in = '0; c_in = '0;
               state_in = (req_op == OP_CLEAR) ? S_CLRD : S_RDW;
            end
         end
         S_CLRD: begin
            addr = {r_ff, c_ff};
            state_in = S_CLRW;
         end
         S_CLRW: begin
            addr = {r_ff, c_ff};
            if (rd.cost != COST_WALL) begin
               we = 1'b1;
               wd = '{pv: 1'b0, pr: '0, pc: '0, vis: 1'b0, cost: COST_UNREACHED};
            end
            if (last_c) begin
               c_in = '0;
               if (last_r) begin
                  rsp_r_in = '0; rsp_c_in = '0; rsp_pv_in = 1'b0;
                  state_in = S_RESP;
               end else begin
                  r_in = r_ff + RW'(1);
                  state_in = S_CLRD;
               end
            end else begin
               c_in = c_ff + CW'(1);
               state_in = S_CLRD;
            end
         end
         S_RDW: begin
            addr = {tr_ff, tc_ff};
            rsp_r_in = '0; rsp_c_in = '0; rsp_pv_in = 1'b0;
            if (!range_ok || op_ff > OP_QUERY) state_in = S_RESP;
            else state_in = S_MOD;
         end
         S_MOD: begin
            addr = {tr_ff, tc_ff};
            state_in = S_RESP;
            case (op_ff)
               OP_WALL:  begin we = 1'b1; wd.cost = COST_WALL; end
               OP_AGENT: begin we = 1'b1; wd.cost = COST_AGENT; end
               OP_SRCH: begin
                  we = 1'b1; wd.cost = '0;
                  r_in = '0; c_in = '0; rv_in = 1'b0;
                  best_in = COST_WALL; found_in = 1'b0; sdone_in = 1'b0;
                  state_in = S_SCAN;
               end
               default: begin
                  if (rd.pv) begin
                     rsp_r_in = 6'(rd.pr); rsp_c_in = 6'(rd.pc); rsp_pv_in = 1'b1;
                  end
               end
            endcase
         end
         S_SCAN: begin
            // pipelined min scan: issue one read per cycle, compare its data in the next cycle
            addr = {r_ff, c_ff};
            if (rv_ff && rd.cost < best_ff && !rd.vis) begin
               best_in = rd.cost; br_in = sr_ff; bc_in = sc_ff; found_in = 1'b1;
            end
            if (!sdone_ff) begin
               rv_in = 1'b1; sr_in = r_ff; sc_in = c_ff;
               if (last_c) begin
                  c_in = '0;
                  if (last_r) begin r_in = '0; sdone_in = 1'b1; end
                  else r_in = r_ff + RW'(1);
               end else begin
                  c_in = c_ff + CW'(1);
               end
            end else begin
               // fetch the winning cell for the visited update
               addr = {br_in, bc_in};
               state_in = S_SCEND;
            end
         end
         S_SCEND: begin
            addr = {br_ff, bc_ff};
            if (!found_ff) begin
               state_in = S_RESP;
            end else if (best_ff >= COST_UNREACHED) begin
               r_in = '0; c_in = '0; state_in = S_FLUSH; flush_in = 1'b0;
            end else begin
               // mark visited; cost is the scanned best value
               we = 1'b1;
               wd = rd;
               wd.vis = 1'b1;
               wd.cost = best_ff;
               bcost_in = best_ff;
               nb_in = 2'd0;
               state_in = S_NBRD;
            end
            if (!found_ff || best_ff >= COST_UNREACHED) begin
               rsp_r_in = '0; rsp_c_in = '0; rsp_pv_in = 1'b0;
            end
         end
         S_NBRD: begin
            addr = {nr, nc};
            state_in = S_NBWR;
         end
         S_NBWR: begin
            addr = {nr, nc};
            if (!rd.vis && rd.cost < COST_AGENT && rd.cost > newc) begin
               we = 1'b1;
               wd.cost = newc; wd.pv = 1'b1; wd.pr = br_ff; wd.pc = bc_ff;
            end
            nb_in = nb_ff + 2'd1;
            if (nb_ff == 2'd3) begin
               r_in = '0; c_in = '0; best_in = COST_WALL; found_in = 1'b0;
               sdone_in = 1'b0; state_in = S_SCAN;
            end else begin
               state_in = S_NBRD;
            end
         end
         S_FLUSH: begin
            // read each cell, write it unless a wall: mark every remaining candidate visited
            addr = {r_ff, c_ff};
            flush_in = !flush_ff;
            if (flush_ff) begin
               if (rd.cost != COST_WALL) begin
                  we = 1'b1; wd.vis = 1'b1;
               end
               if (last_c) begin
                  c_in = '0;
                  if (last_r) state_in = S_RESP;
                  else r_in = r_ff + RW'(1);
               end else begin
                  c_in = c_ff + CW'(1);
               end
            end
         end
         S_RESP: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               out_r_in = rsp_r_ff; out_c_in = rsp_c_ff; out_pv_in = rsp_pv_ff;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         init_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         rv_ff        <= 1'b0;
      end else begin
         state_ff     <= state_in;
         init_ff      <= init_in;
         rsp_valid_ff <= rsp_valid_in;
         rv_ff        <= rv_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff <= op_in; tr_ff <= tr_in; tc_ff <= tc_in; hr_ff <= hr_in; hc_ff <= hc_in;
      r_ff <= r_in; c_ff <= c_in; br_ff <= br_in; bc_ff <= bc_in;
      best_ff <= best_in; bcost_ff <= bcost_in; found_ff <= found_in;
      flush_ff <= flush_in; nb_ff <= nb_in;
      sr_ff <= sr_in; sc_ff <= sc_in; sdone_ff <= sdone_in;
      rsp_r_ff <= rsp_r_in; rsp_c_ff <= rsp_c_in; rsp_pv_ff <= rsp_pv_in;
      out_r_ff <= out_r_in; out_c_ff <= out_c_in; out_pv_ff <= out_pv_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_pred_row   = out_r_ff;
   assign rsp_pred_col   = out_c_ff;
   assign rsp_pred_valid = out_pv_ff;

endmodule

FILE: design/gspe_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gspe_ram
// single port synchronous ram, one write or read per cycle, registered read
// ----------------------------------------------------------------------------
module gspe_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;

endmodule

FILE: tb/tb_grid_shortest_path_engine_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_grid_shortest_path_engine_core
// drives csr writes and clear, mark, search, query and unused requests into the engine and
// compares each response with a grid shortest path predictor kept alongside or a directed expectation
// ----------------------------------------------------------------------------
module tb_grid_shortest_path_engine_core;
   import gspe_pkg::*;

   localparam int GRID_COLS = 64;
   localparam int NCELL = 64 * 64;
   localparam logic [2:0] OP_UNUSED_LO = 3'd5;
   localparam logic [2:0] OP_UNUSED_HI = 3'd7;

   typedef struct {
      logic [5:0] prow;
      logic [5:0] pcol;
      logic       pvalid;
   } pred_type;

   typedef struct {
      bit         is_csr;
      logic       csr_idx;
      logic [6:0] csr_val;
      logic [2:0] op;
      logic [5:0] row;
      logic [5:0] col;
      bit         typed;
      pred_type   want;
   } stim_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       csr_we = 1'b0;
   logic       csr_index = 1'b0;
   logic [6:0] csr_wdata = '0;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [2:0] req_op = '0;
   logic [5:0] req_row = '0;
   logic [5:0] req_col = '0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [5:0] rsp_pred_row;
   logic [5:0] rsp_pred_col;
   logic       rsp_pred_valid;

   grid_shortest_path_engine_core uut (
      .clock(clock), .reset(reset),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_op(req_op), .req_row(req_row), .req_col(req_col),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_pred_row(rsp_pred_row), .rsp_pred_col(rsp_pred_col),
      .rsp_pred_valid(rsp_pred_valid)
   );

   // predictor state
   logic [COST_W-1:0] grid_cost [NCELL];
   bit                grid_seen [NCELL];
   pred_type          grid_link [NCELL];
   int                rows_now;
   int                cols_now;

   pred_type pending_links[$];
   int       mismatches = 0;
   bit       long_hold_go = 1'b0;
   int       accepted_work = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #50_000_000;
      $display("simulation failed");
      $finish;
   end

   function automatic int clamp_dim(logic [6:0] v);
      if (v == 7'd0) return 1;
      if (v > 7'd64) return 64;
      return int'(v);
   endfunction

   function automatic void relax_into(int r, int c, int tr, int tc);
      int from;
      int dest;
      int step_cost;
      from = r * GRID_COLS + c;
      dest = tr * GRID_COLS + tc;
      step_cost = int'(grid_cost[from]) + 1;
      if (!grid_seen[dest] && grid_cost[dest] < COST_AGENT &&
          int'(grid_cost[dest]) > step_cost) begin
         grid_cost[dest] = step_cost[COST_W-1:0];
         grid_link[dest] = '{r[5:0], c[5:0], 1'b1};
      end
   endfunction

   function automatic void flood_from(int sr, int sc);
      int best;
      int br;
      int bc;
      bit found;
      grid_cost[sr * GRID_COLS + sc] = '0;
      for (int n = 0; n < rows_now * cols_now; n++) begin
         best = int'(COST_WALL);
         br = 0;
         bc = 0;
         found = 1'b0;
         for (int r = 0; r < rows_now; r++)
            for (int c = 0; c < cols_now; c++)
               if (int'(grid_cost[r * GRID_COLS + c]) < best &&
                   !grid_seen[r * GRID_COLS + c]) begin
                  best = int'(grid_cost[r * GRID_COLS + c]);
                  br = r;
                  bc = c;
                  found = 1'b1;
               end
         if (!found) break;
         if (best >= int'(COST_UNREACHED)) begin
            // nothing left to relax, remaining candidates only get marked
            for (int r = 0; r < rows_now; r++)
               for (int c = 0; c < cols_now; c++)
                  if (grid_cost[r * GRID_COLS + c] < COST_WALL)
                     grid_seen[r * GRID_COLS + c] = 1'b1;
            break;
         end
         grid_seen[br * GRID_COLS + bc] = 1'b1;
         relax_into(br, bc, (br > 0) ? br - 1 : 0, bc);
         relax_into(br, bc, (br + 1 < rows_now) ? br + 1 : rows_now - 1, bc);
         relax_into(br, bc, br, (bc > 0) ? bc - 1 : 0);
         relax_into(br, bc, br, (bc + 1 < cols_now) ? bc + 1 : cols_now - 1);
      end
   endfunction

   function automatic pred_type apply_request(logic [2:0] op, logic [5:0] row, logic [5:0] col);
      pred_type res;
      bit       in_grid;
      int       idx;
      res = '{6'd0, 6'd0, 1'b0};
      in_grid = (int'(row) < rows_now) && (int'(col) < cols_now);
      idx = int'(row) * GRID_COLS + int'(col);
      if (op == OP_CLEAR) begin
         for (int r = 0; r < rows_now; r++)
            for (int c = 0; c < cols_now; c++)
               if (grid_cost[r * GRID_COLS + c] != COST_WALL) begin
                  grid_cost[r * GRID_COLS + c] = COST_UNREACHED;
                  grid_seen[r * GRID_COLS + c] = 1'b0;
                  grid_link[r * GRID_COLS + c] = '{6'd0, 6'd0, 1'b0};
               end
      end else if (in_grid) begin
         case (op)
            OP_WALL: begin
               grid_cost[idx] = COST_WALL;
            end
            OP_AGENT: begin
               grid_cost[idx] = COST_AGENT;
            end
            OP_SRCH: begin
               flood_from(int'(row), int'(col));
            end
            OP_QUERY: begin
               if (grid_link[idx].pvalid) res = grid_link[idx];
            end
            default: begin
            end
         endcase
      end
      return res;
   endfunction

   // response side: random stalls plus one long hold-off on request
   initial begin
      int stall_left;
      bit long_done;
      stall_left = 0;
      long_done = 1'b0;
      forever begin
         @(posedge clock);
         if (long_hold_go && !long_done) begin
            long_done = 1'b1;
            stall_left = 600;
         end
         if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else if ($urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            stall_left = ($urandom_range(0, 9) == 0) ? int'($urandom_range(10, 60))
                                                     : int'($urandom_range(0, 3));
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      pred_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_links.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("response with nothing pending at %0t", $realtime);
         end else begin
            want = pending_links.pop_front();
            if (rsp_pred_row !== want.prow || rsp_pred_col !== want.pcol ||
                rsp_pred_valid !== want.pvalid) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch at %0t: expected row %0d col %0d valid %0d, got %0d %0d %0d",
                           $realtime, want.prow, want.pcol, want.pvalid,
                           rsp_pred_row, rsp_pred_col, rsp_pred_valid);
            end
         end
      end
   end

   task automatic send_request(logic [2:0] op, logic [5:0] row, logic [5:0] col, bit typed,
                               pred_type want);
      pred_type got;
      int gap;
      gap = ($urandom_range(0, 2) == 0) ?
            (($urandom_range(0, 9) == 0) ? int'($urandom_range(10, 40))
                                         : int'($urandom_range(1, 3))) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_op <= op;
      req_row <= row;
      req_col <= col;
      do @(posedge clock); while (!req_ready);
      got = apply_request(op, row, col);
      pending_links.push_back(typed ? want : got);
      if (op == OP_CLEAR ||
          (op <= OP_QUERY && int'(row) < rows_now && int'(col) < cols_now))
         accepted_work++;
   endtask

   task automatic drain_and_settle();
      req_valid <= 1'b0;
      while (pending_links.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_csr(logic idx, logic [6:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      if (idx == CSR_ROWS) rows_now = clamp_dim(val);
      else cols_now = clamp_dim(val);
   endtask

   task automatic random_cell(output logic [5:0] r, output logic [5:0] c);
      r = 6'($urandom_range(0, rows_now - 1));
      c = 6'($urandom_range(0, cols_now - 1));
   endtask

   stim_type directed_rows[] = '{
      '{1'b0, CSR_ROWS, 7'd0,  OP_QUERY,     6'd63, 6'd63, 1'b1, '{6'd0, 6'd0, 1'b0}},
      '{1'b0, CSR_ROWS, 7'd0,  OP_UNUSED_LO, 6'd0,  6'd0,  1'b1, '{6'd0, 6'd0, 1'b0}},
      '{1'b0, CSR_ROWS, 7'd0,  OP_UNUSED_HI, 6'd63, 6'd63, 1'b1, '{6'd0, 6'd0, 1'b0}},
      '{1'b0, CSR_ROWS, 7'd0,  OP_WALL,      6'd63, 6'd63, 1'b1, '{6'd0, 6'd0, 1'b0}},
      '{1'b0, CSR_ROWS, 7'd0,  OP_AGENT,     6'd0,  6'd0,  1'b1, '{6'd0, 6'd0, 1'b0}},
      '{1'b0, CSR_ROWS, 7'd0,  OP_CLEAR,     6'd0,  6'd0,  1'b1, '{6'd0, 6'd0, 1'b0}},
      '{1'b1, CSR_ROWS, 7'd0,  OP_CLEAR,     6'd0,  6'd0,  1'b0, '{6'd0, 6'd0, 1'b0}},
      '{1'b1, CSR_COLS, 7'd127, OP_CLEAR,    6'd0,  6'd0,  1'b0, '{6'd0, 6'd0, 1'b0}},
      '{1'b0, CSR_ROWS, 7'd0,  OP_SRCH,      6'd0,  6'd63, 1'b1, '{6'd0, 6'd0, 1'b0}},
      '{1'b0, CSR_ROWS, 7'd0,  OP_QUERY,     6'd0,  6'd0,  1'b1, '{6'd0, 6'd1, 1'b1}},
      '{1'b0, CSR_ROWS, 7'd0,  OP_QUERY,     6'd1,  6'd0,  1'b1, '{6'd0, 6'd0, 1'b0}},
      '{1'b1, CSR_ROWS, 7'd3,  OP_CLEAR,     6'd0,  6'd0,  1'b0, '{6'd0, 6'd0, 1'b0}},
      '{1'b1, CSR_COLS, 7'd3,  OP_CLEAR,     6'd0,  6'd0,  1'b0, '{6'd0, 6'd0, 1'b0}},
      '{1'b0, CSR_ROWS, 7'd0,  OP_CLEAR,     6'd0,  6'd0,  1'b1, '{6'd0, 6'd0, 1'b0}},
      '{1'b0, CSR_ROWS, 7'd0,  OP_WALL,      6'd1,  6'd1,  1'b1, '{6'd0, 6'd0, 1'b0}},
      '{1'b0, CSR_ROWS, 7'd0,  OP_AGENT,     6'd0,  6'd1,  1'b1, '{6'd0, 6'd0, 1'b0}},
      '{1'b0, CSR_ROWS, 7'd0,  OP_SRCH,      6'd0,  6'd0,  1'b0, '{6'd0, 6'd0, 1'b0}},
      '{1'b0, CSR_ROWS, 7'd0,  OP_QUERY,     6'd2,  6'd2,  1'b0, '{6'd0, 6'd0, 1'b0}},
      '{1'b0, CSR_ROWS, 7'd0,  OP_QUERY,     6'd0,  6'd1,  1'b1, '{6'd0, 6'd0, 1'b0}},
      // wall as source, grid not cleared in between
      '{1'b0, CSR_ROWS, 7'd0,  OP_SRCH,      6'd1,  6'd1,  1'b0, '{6'd0, 6'd0, 1'b0}},
      '{1'b0, CSR_ROWS, 7'd0,  OP_QUERY,     6'd1,  6'd2,  1'b0, '{6'd0, 6'd0, 1'b0}},
      '{1'b1, CSR_ROWS, 7'd64, OP_CLEAR,     6'd0,  6'd0,  1'b0, '{6'd0, 6'd0, 1'b0}},
      '{1'b1, CSR_COLS, 7'd2,  OP_CLEAR,     6'd0,  6'd0,  1'b0, '{6'd0, 6'd0, 1'b0}},
      '{1'b0, CSR_ROWS, 7'd0,  OP_SRCH,      6'd63, 6'd1,  1'b0, '{6'd0, 6'd0, 1'b0}},
      '{1'b0, CSR_ROWS, 7'd0,  OP_QUERY,     6'd0,  6'd0,  1'b0, '{6'd0, 6'd0, 1'b0}},
      '{1'b0, CSR_ROWS, 7'd0,  OP_QUERY,     6'd62, 6'd0,  1'b0, '{6'd0, 6'd0, 1'b0}}
   };

   initial begin
      pred_type none;
      logic [5:0] r;
      logic [5:0] c;
      logic [6:0] v;
      int pick;
      none = '{6'd0, 6'd0, 1'b0};
      rows_now = 64;
      cols_now = 64;
      for (int i = 0; i < NCELL; i++) begin
         grid_cost[i] = COST_UNREACHED;
         grid_seen[i] = 1'b0;
         grid_link[i] = none;
      end
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         if (directed_rows[i].is_csr) begin
            drain_and_settle();
            write_csr(directed_rows[i].csr_idx, directed_rows[i].csr_val);
         end else begin
            send_request(directed_rows[i].op, directed_rows[i].row, directed_rows[i].col,
                         directed_rows[i].typed, directed_rows[i].want);
         end
      end

      accepted_work = 0;
      while (accepted_work < 100) begin
         drain_and_settle();
         v = ($urandom_range(0, 7) == 0) ? 7'($urandom_range(0, 1) ? 0 : $urandom_range(65, 127))
                                         : 7'($urandom_range(1, 6));
         write_csr(CSR_ROWS, v);
         v = ($urandom_range(0, 7) == 0) ? 7'($urandom_range(0, 1) ? 0 : 1)
                                         : 7'($urandom_range(1, 6));
         write_csr(CSR_COLS, v);
         // large row counts only with one column so searches stay short
         if (rows_now > 6 && cols_now > 1) write_csr(CSR_COLS, 7'd1);
         if (accepted_work > 30) long_hold_go = 1'b1;
         if ($urandom_range(0, 4) != 0)
            send_request(OP_CLEAR, 6'($urandom), 6'($urandom), 1'b0, none);
         repeat ($urandom_range(0, 4)) begin
            random_cell(r, c);
            send_request($urandom_range(0, 1) ? OP_WALL : OP_AGENT, r, c, 1'b0, none);
         end
         random_cell(r, c);
         send_request(OP_SRCH, r, c, 1'b0, none);
         repeat ($urandom_range(2, 8)) begin
            pick = int'($urandom_range(0, 9));
            if (pick < 7) begin
               random_cell(r, c);
               send_request(OP_QUERY, r, c, 1'b0, none);
            end else begin
               // noise: any op, any cell
               send_request(3'($urandom_range(0, 7)), 6'($urandom), 6'($urandom), 1'b0, none);
            end
         end
      end

      drain_and_settle();
      repeat (200) @(posedge clock);
      if (mismatches == 0 && pending_links.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
